/* rtl/aept_pkg.sv */
// Package for the adaptive error poll timer: widths, codes, register indexes
// and the period clamp function. No dependencies.
`default_nettype none

package aept_pkg;

  localparam int PERIOD_W = 20;
  localparam int ERR_W    = 8;
  localparam int DUMP_W   = 4;
  localparam int DIV_W    = ERR_W + 1;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = ADDR_W - 2;

  localparam logic [ERR_W-1:0]    ERR_MAX   = '1;
  localparam logic [DUMP_W-1:0]   DUMP_MAX  = '1;

  localparam logic                VARIABLE_MODE_RST  = 1'b1;
  localparam logic [PERIOD_W-1:0] PERIOD_INITIAL_RST = PERIOD_W'(8000);
  localparam logic [PERIOD_W-1:0] PERIOD_MIN_RST     = PERIOD_W'(2000);
  localparam logic [PERIOD_W-1:0] PERIOD_MAX_RST     = PERIOD_W'(16000);
  localparam logic [DUMP_W-1:0]   DUMP_THRESHOLD_RST = DUMP_W'(10);

  localparam logic [IDX_W-1:0] REG_VARIABLE_MODE  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_PERIOD_INITIAL = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_PERIOD_MIN     = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_PERIOD_MAX     = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_DUMP_THRESHOLD = IDX_W'(4);

  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  localparam logic KIND_POLL   = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_DISMISS = 2'd1,
    ACT_COMMIT  = 2'd2,
    ACT_DUMP    = 2'd3
  } action_t;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_DIVIDE = 1'b1
  } state_t;

  function automatic logic [PERIOD_W-1:0] clamp_period(
    input logic [PERIOD_W:0]   v,
    input logic [PERIOD_W-1:0] lo,
    input logic [PERIOD_W-1:0] hi
  );
    logic [PERIOD_W:0] t;
    t = (v > {1'b0, hi}) ? {1'b0, hi} : v;
    if (t < {1'b0, lo}) begin
      t = {1'b0, lo};
    end
    return t[PERIOD_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/adaptive_error_poll_timer_core.sv */
// Top level of the adaptive error poll timer with its register port.
// Depends on aept_pkg and aept_div.
//
// Ticks and reports are taken one per cycle and give their result in the
// next cycle. A report that ends a round in variable mode after a round with
// errors runs the period through the restoring divider, one quotient
// bit per cycle, and the block takes no new item meanwhile. A pending
// result that is stalled also holds off the next item. Registers sit at
// byte addresses 0, 4, 8, 12 and 16; the user must write them only while
// the block is idle, which the block itself does not enforce.
`default_nettype none

module adaptive_error_poll_timer_core import aept_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                op,
  input  logic                error_found,
  input  logic                record_present,
  input  logic                notify_enabled,
  input  logic                last_report,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                kind,
  output logic [1:0]          action,
  output logic                round_done,
  output logic [PERIOD_W-1:0] new_period,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  logic                variable_mode;
  logic [PERIOD_W-1:0] period_initial;
  logic [PERIOD_W-1:0] period_min;
  logic [PERIOD_W-1:0] period_max;
  logic [DUMP_W-1:0]   dump_threshold;

  logic [PERIOD_W-1:0] current_period;
  logic [PERIOD_W-1:0] time_left;
  logic [ERR_W-1:0]    round_errors;
  logic [DUMP_W-1:0]   dump_counter;
  logic                awaiting;
  action_t             pend_action;

  state_t state;
  state_t state_next;

  logic                cfg_we;
  logic [IDX_W-1:0]    cfg_idx;
  logic                accept;
  logic                is_report;
  logic                rec_err;
  logic [ERR_W-1:0]    errors_next;
  logic [DUMP_W-1:0]   dump_next;
  action_t             rep_action;
  logic                fires;
  logic                report_ok;
  logic                need_div;
  logic                emit_now;
  logic                emit_div;
  logic [PERIOD_W-1:0] fast_period;
  logic [PERIOD_W-1:0] div_period;
  logic                div_start;
  logic                div_done;
  logic [PERIOD_W-1:0] quotient;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = paddr[ADDR_W-1:2];

  always_comb begin
    case (cfg_idx)
      REG_VARIABLE_MODE:  prdata = DATA_W'(variable_mode);
      REG_PERIOD_INITIAL: prdata = DATA_W'(period_initial);
      REG_PERIOD_MIN:     prdata = DATA_W'(period_min);
      REG_PERIOD_MAX:     prdata = DATA_W'(period_max);
      REG_DUMP_THRESHOLD: prdata = DATA_W'(dump_threshold);
      default:            prdata = '0;
    endcase
  end

  assign accept    = in_valid & ~in_stall;
  assign is_report = (op == OP_REPORT);
  assign rec_err   = record_present & error_found;

  always_comb begin
    errors_next = round_errors;
    if (rec_err && round_errors != ERR_MAX) begin
      errors_next = round_errors + ERR_W'(1);
    end
    dump_next = dump_counter;
    if (rec_err && !notify_enabled && dump_counter != DUMP_MAX) begin
      dump_next = dump_counter + DUMP_W'(1);
    end
    if (rec_err) begin
      if (notify_enabled) begin
        rep_action = ACT_COMMIT;
      end else begin
        rep_action = (dump_next >= dump_threshold) ? ACT_DUMP : ACT_DISMISS;
      end
    end else if (record_present) begin
      rep_action = ACT_DISMISS;
    end else begin
      rep_action = ACT_NONE;
    end
  end

  assign fires     = !is_report && !awaiting && (time_left <= PERIOD_W'(1));
  assign report_ok = is_report && awaiting;
  assign need_div  = report_ok && last_report && variable_mode && (errors_next != '0);
  assign emit_now  = accept && (fires || (report_ok && !need_div));
  assign emit_div  = (state == ST_DIVIDE) && div_done;

  assign fast_period = variable_mode ?
      clamp_period({current_period, 1'b0}, period_min, period_max) : current_period;
  assign div_period  = clamp_period({1'b0, quotient}, period_min, period_max);

  aept_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (current_period),
    .divisor  ({1'b0, errors_next} + DIV_W'(1)),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && need_div) begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != ST_IDLE) || (out_valid && out_stall);
    div_start = (state == ST_IDLE) && in_valid && !in_stall && need_div;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      out_valid      <= 1'b0;
      variable_mode  <= VARIABLE_MODE_RST;
      period_initial <= PERIOD_INITIAL_RST;
      period_min     <= PERIOD_MIN_RST;
      period_max     <= PERIOD_MAX_RST;
      dump_threshold <= DUMP_THRESHOLD_RST;
      current_period <= PERIOD_INITIAL_RST;
      time_left      <= PERIOD_INITIAL_RST;
      round_errors   <= '0;
      dump_counter   <= '0;
      awaiting       <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= emit_now || emit_div || (out_valid && out_stall);
      if (cfg_we) begin
        case (cfg_idx)
          REG_VARIABLE_MODE: variable_mode <= pwdata[0];
          REG_PERIOD_INITIAL: begin
            period_initial <= pwdata[PERIOD_W-1:0];
            current_period <= pwdata[PERIOD_W-1:0];
            time_left      <= pwdata[PERIOD_W-1:0];
          end
          REG_PERIOD_MIN:     period_min     <= pwdata[PERIOD_W-1:0];
          REG_PERIOD_MAX:     period_max     <= pwdata[PERIOD_W-1:0];
          REG_DUMP_THRESHOLD: dump_threshold <= pwdata[DUMP_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (!is_report && !awaiting) begin
          if (fires) begin
            time_left <= '0;
            awaiting  <= 1'b1;
          end else begin
            time_left <= time_left - PERIOD_W'(1);
          end
        end
        if (report_ok) begin
          dump_counter <= dump_next;
          round_errors <= last_report ? '0 : errors_next;
          if (last_report) begin
            awaiting <= 1'b0;
            if (!need_div) begin
              current_period <= fast_period;
              time_left      <= fast_period;
            end
          end
        end
      end
      if (emit_div) begin
        current_period <= div_period;
        time_left      <= div_period;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && need_div) begin
      pend_action <= rep_action;
    end
    if (emit_div) begin
      kind       <= KIND_REPORT;
      action     <= pend_action;
      round_done <= 1'b1;
      new_period <= div_period;
    end else if (emit_now) begin
      if (fires) begin
        kind       <= KIND_POLL;
        action     <= ACT_NONE;
        round_done <= 1'b0;
        new_period <= '0;
      end else begin
        kind       <= KIND_REPORT;
        action     <= rep_action;
        round_done <= last_report;
        new_period <= last_report ? fast_period : '0;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/aept_div.sv */
// Restoring divider that produces one quotient bit per cycle.
// Depends on aept_pkg for the period and divisor widths.
`default_nettype none

module aept_div import aept_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [PERIOD_W-1:0] dividend,
  input  logic [DIV_W-1:0]    divisor,
  output logic                done,
  output logic [PERIOD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(PERIOD_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(PERIOD_W - 1);

  logic                busy;
  logic [CNT_W-1:0]    cnt;
  logic [DIV_W-1:0]    rem;
  logic [DIV_W-1:0]    dvs;
  logic [PERIOD_W-1:0] quo;
  logic [DIV_W:0]      shifted;
  logic [DIV_W+1:0]    diff;
  logic                borrow;

  assign shifted = {rem, quo[PERIOD_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs};
  assign borrow  = diff[DIV_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[PERIOD_W-2:0], ~borrow};
      rem <= borrow ? shifted[DIV_W-1:0] : diff[DIV_W-1:0];
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

/* rtl/aept_checker.sv */
// Port-level checks for the adaptive error poll timer, bound to the top level.
// Depends on aept_pkg and adaptive_error_poll_timer_core.
`default_nettype none

module aept_checker import aept_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_stall,
  input logic                kind,
  input logic [1:0]          action,
  input logic                round_done,
  input logic [PERIOD_W-1:0] new_period
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result item dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(kind) && $stable(action) &&
      $stable(round_done) && $stable(new_period))
    else $error("stalled result item changed");

  a_poll_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_POLL |->
      action == ACT_NONE && !round_done && new_period == '0)
    else $error("poll request carries report fields");

  a_period_only_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && !round_done |-> new_period == '0)
    else $error("period shown without a finished round");

endmodule

bind adaptive_error_poll_timer_core aept_checker u_aept_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .kind       (kind),
  .action     (action),
  .round_done (round_done),
  .new_period (new_period)
);

`default_nettype wire

/* dv/adaptive_error_poll_timer_core_test.sv */
// Self-checking testbench for adaptive_error_poll_timer_core: directed and random
// tick and report items, register writes over the APB port, and backpressure.
// Depends on aept_pkg and the RTL of the block only.
module adaptive_error_poll_timer_core_test;
  import aept_pkg::*;

  localparam int CYCLE_LIMIT      = 1000000;
  localparam int DRAIN_CYCLES     = 30;
  localparam int HOLD_CYCLES      = 400;
  localparam int RANDOM_ITEMS     = 540;
  localparam int SATURATE_REPORTS = 300;
  localparam logic [IDX_W-1:0] REG_SPARE = IDX_W'(5);

  typedef struct packed {
    logic op;
    logic err;
    logic rec;
    logic notify;
    logic last;
  } poll_item_t;

  typedef struct packed {
    logic                kind;
    action_t             action;
    logic                done;
    logic [PERIOD_W-1:0] period;
  } outcome_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                op = 1'b0;
  logic                error_found = 1'b0;
  logic                record_present = 1'b0;
  logic                notify_enabled = 1'b0;
  logic                last_report = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                kind;
  logic [1:0]          action;
  logic                round_done;
  logic [PERIOD_W-1:0] new_period;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  logic                cfg_variable   = VARIABLE_MODE_RST;
  logic [PERIOD_W-1:0] cfg_initial    = PERIOD_INITIAL_RST;
  logic [PERIOD_W-1:0] cfg_min        = PERIOD_MIN_RST;
  logic [PERIOD_W-1:0] cfg_max        = PERIOD_MAX_RST;
  logic [DUMP_W-1:0]   cfg_dump_limit = DUMP_THRESHOLD_RST;
  logic [PERIOD_W-1:0] period_now     = PERIOD_INITIAL_RST;
  logic [PERIOD_W-1:0] ticks_left     = PERIOD_INITIAL_RST;
  logic [ERR_W-1:0]    round_err_count = '0;
  logic [DUMP_W-1:0]   dump_count     = '0;
  logic                poll_pending   = 1'b0;

  outcome_t outcomes_due[$];
  int       mismatches  = 0;
  int       cycle_count = 0;
  int       stall_left  = 0;
  bit       idle_on     = 1'b1;
  logic     hold_active = 1'b0;

  adaptive_error_poll_timer_core u_dut (.*);

  always #5 clk = ~clk;

  function automatic bit advance_timer(input poll_item_t it, output outcome_t res);
    int unsigned p;
    res = '0;
    if (it.op == OP_TICK) begin
      if (poll_pending) return 1'b0;
      if (ticks_left > 1) begin
        ticks_left--;
        return 1'b0;
      end
      ticks_left = '0;
      poll_pending = 1'b1;
      res.kind = KIND_POLL;
      res.action = ACT_NONE;
      return 1'b1;
    end
    if (!poll_pending) return 1'b0;
    res.kind = KIND_REPORT;
    res.action = ACT_NONE;
    if (it.rec && it.err) begin
      if (round_err_count != ERR_MAX) round_err_count++;
      if (it.notify) begin
        res.action = ACT_COMMIT;
      end else begin
        if (dump_count != DUMP_MAX) dump_count++;
        res.action = (dump_count >= cfg_dump_limit) ? ACT_DUMP : ACT_DISMISS;
      end
    end else if (it.rec) begin
      res.action = ACT_DISMISS;
    end
    if (it.last) begin
      p = period_now;
      if (cfg_variable) begin
        if (round_err_count != 0) begin
          p = p / (round_err_count + 1);
        end else begin
          p = p * 2;
        end
        if (p > cfg_max) p = cfg_max;
        if (p < cfg_min) p = cfg_min;
      end
      period_now = PERIOD_W'(p);
      ticks_left = period_now;
      round_err_count = '0;
      poll_pending = 1'b0;
      res.done = 1'b1;
      res.period = period_now;
    end
    return 1'b1;
  endfunction

  task automatic send_item(input poll_item_t it);
    int gap;
    outcome_t res;
    gap = idle_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= it.op;
    error_found <= it.err;
    record_present <= it.rec;
    notify_enabled <= it.notify;
    last_report <= it.last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (advance_timer(it, res)) outcomes_due.push_back(res);
  endtask

  task automatic tick();
    poll_item_t it;
    it = poll_item_t'(5'($urandom));
    it.op = OP_TICK;
    send_item(it);
  endtask

  task automatic report(input int e, input int r, input int n, input int l);
    send_item('{OP_REPORT, 1'(e), 1'(r), 1'(n), 1'(l)});
  endtask

  task automatic tick_until_poll();
    while (!poll_pending) tick();
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (outcomes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_VARIABLE_MODE: cfg_variable = value[0];
      REG_PERIOD_INITIAL: begin
        cfg_initial = value[PERIOD_W-1:0];
        period_now = cfg_initial;
        ticks_left = cfg_initial;
      end
      REG_PERIOD_MIN: cfg_min = value[PERIOD_W-1:0];
      REG_PERIOD_MAX: cfg_max = value[PERIOD_W-1:0];
      REG_DUMP_THRESHOLD: cfg_dump_limit = value[DUMP_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic test_report_actions();
    wait_idle();
    write_reg(REG_PERIOD_INITIAL, 2);
    tick();
    tick();
    report(1, 1, 1, 0);
    report(0, 1, 0, 0);
    report(0, 0, 1, 0);
    report(1, 0, 0, 0);
    tick();
    report(1, 1, 0, 0);
    report(1, 1, 0, 1);
    report(1, 1, 1, 1);
    wait_idle();
    write_reg(REG_DUMP_THRESHOLD, 3);
    write_reg(REG_PERIOD_INITIAL, 1);
    tick();
    report(1, 1, 0, 0);
    report(1, 1, 0, 1);
  endtask

  task automatic test_zero_period();
    wait_idle();
    write_reg(REG_VARIABLE_MODE, 0);
    write_reg(REG_PERIOD_INITIAL, 0);
    tick();
    report(0, 0, 0, 1);
    tick();
    report(0, 1, 0, 1);
    wait_idle();
    write_reg(REG_VARIABLE_MODE, 1);
    tick();
    report(0, 0, 0, 1);
  endtask

  task automatic test_period_clamps();
    wait_idle();
    write_reg(REG_PERIOD_MIN, 1);
    write_reg(REG_PERIOD_MAX, 1048575);
    write_reg(REG_PERIOD_INITIAL, 3);
    tick_until_poll();
    wait_idle();
    write_reg(REG_PERIOD_INITIAL, 1048575);
    report(0, 1, 1, 1);
    wait_idle();
    write_reg(REG_PERIOD_INITIAL, 1);
    tick();
    wait_idle();
    write_reg(REG_PERIOD_INITIAL, 1048575);
    report(1, 1, 1, 1);
    wait_idle();
    write_reg(REG_PERIOD_MIN, 1048575);
    write_reg(REG_PERIOD_MAX, 1);
    write_reg(REG_PERIOD_INITIAL, 1);
    tick();
    report(0, 0, 0, 1);
    wait_idle();
    write_reg(REG_SPARE, '1);
    write_reg(REG_PERIOD_MIN, 1);
    write_reg(REG_PERIOD_MAX, 1048575);
    write_reg(REG_PERIOD_INITIAL, 1);
    tick_until_poll();
  endtask

  task automatic test_error_saturation();
    wait_idle();
    write_reg(REG_DUMP_THRESHOLD, 15);
    write_reg(REG_PERIOD_INITIAL, 1048575);
    tick_until_poll();
    for (int i = 0; i < SATURATE_REPORTS; i++) begin
      report(1, 1, (i < 20) ? 0 : $urandom_range(0, 1), 0);
    end
    report(1, 1, 1, 1);
  endtask

  task automatic test_backpressure();
    wait_idle();
    write_reg(REG_PERIOD_MIN, 1);
    write_reg(REG_PERIOD_MAX, 1);
    write_reg(REG_PERIOD_INITIAL, 1);
    idle_on = 1'b0;
    fork
      begin
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
      end
    join_none
    repeat (20) begin
      tick_until_poll();
      report($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1), 1);
    end
    idle_on = 1'b1;
  endtask

  task automatic test_random_rounds();
    int sent;
    int reports;
    logic is_last;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      idle_on = ($urandom_range(0, 3) != 0);
      write_reg(REG_VARIABLE_MODE, $urandom_range(0, 1));
      write_reg(REG_PERIOD_MIN, $urandom_range(1, 4));
      write_reg(REG_PERIOD_MAX, $urandom_range(1, 16));
      write_reg(REG_DUMP_THRESHOLD, $urandom_range(1, 15));
      write_reg(REG_PERIOD_INITIAL, $urandom_range(1, 12));
      repeat (6) begin
        while (!poll_pending) begin
          tick();
          sent++;
        end
        reports = $urandom_range(1, 8);
        for (int k = 0; k < reports; k++) begin
          if ($urandom_range(0, 9) == 0) tick();
          is_last = (k == reports - 1) || ($urandom_range(0, 19) == 0);
          if (poll_pending) sent++;
          report($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                 int'(is_last));
        end
        if ($urandom_range(0, 4) == 0) begin
          report($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                 $urandom_range(0, 1));
        end
      end
    end
    idle_on = 1'b1;
  endtask

  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      stall_left = idle_on ? $urandom_range(0, 11) : 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_stall <= hold_active || (stall_left > 0);
  end

  always @(posedge clk) begin
    outcome_t want;
    if (!rst && out_valid && !out_stall) begin
      if (outcomes_due.size() == 0) begin
        $error("result with nothing expected: kind %0d action %0d", kind, action);
        mismatches++;
      end else begin
        want = outcomes_due.pop_front();
        if (kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, kind);
          mismatches++;
        end
        if (action !== want.action) begin
          $error("action: expected %0d, got %0d", want.action, action);
          mismatches++;
        end
        if (round_done !== want.done) begin
          $error("round_done: expected %0d, got %0d", want.done, round_done);
          mismatches++;
        end
        if (new_period !== want.period) begin
          $error("new_period: expected %0d, got %0d", want.period, new_period);
          mismatches++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_report_actions();
    test_zero_period();
    test_period_clamps();
    test_error_saturation();
    test_backpressure();
    test_random_rounds();
    wait_idle();
    if (mismatches == 0 && outcomes_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
